// ===== rtl/sedt_pkg.sv =====
`default_nettype none
package sedt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 10;
  localparam int DIST_W   = 32;
  localparam int MM_W     = 24;
  localparam logic [MM_W-1:0] MM_RESET = 24'd65536;

  // squared distance, wide enough for a row of up to 4096 positions
  localparam int SQ_W   = 32;
  localparam int FRAC_W = 16;
  localparam int RAD_W  = SQ_W + FRAC_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SCL_W  = ROOT_W + MM_W;

  // separator numerator and its quotient
  localparam int NUM_W = SQ_W + 1;
  localparam int W_W   = NUM_W + 2;

  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       row_end;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [DIST_W-1:0] distance;
    logic                     final_res;
  } rsp_t;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_CALC,
    PH_READ
  } phase_t;

  typedef enum logic [4:0] {
    E_IDLE,
    E_INIT,
    F_RD_U,
    F_GU,
    F_TOP,
    F_SITE,
    F_GI,
    F_SQ,
    F_CMP,
    F_DIV,
    F_NEXT,
    B_RD,
    B_SITE,
    B_G,
    B_SQ,
    B_SUM,
    B_ROOT,
    B_SCALE,
    B_WRITE,
    B_NEXT
  } eng_state_t;

  // height of a column sample in the chosen half (outside or inner)
  function automatic logic [SAMPLE_W-1:0] gval(input logic [SAMPLE_W-1:0] raw,
                                               input logic inner);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(-raw);
    if (inner) begin
      return raw[SAMPLE_W-1] ? neg : '0;
    end
    return raw[SAMPLE_W-1] ? '0 : raw;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sedt_ram.sv =====
`default_nettype none
module sedt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/sedt_isqrt.sv =====
`default_nettype none
module sedt_isqrt #(
  parameter int RAD_W = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [RAD_W-1:0]   radicand,
  output logic                    done,
  output logic [RAD_W/2-1:0]      root
);

  localparam int R_W = RAD_W / 2;
  localparam int C_W = $clog2(R_W + 1);

  logic             busy;
  logic [C_W-1:0]   cnt;
  logic [RAD_W-1:0] rad;
  logic [R_W+1:0]   rem;
  logic [R_W+1:0]   rem_sh;
  logic [R_W+1:0]   trial;
  logic             fits;

  // bring down two radicand bits and try the next root bit
  assign rem_sh = {rem[R_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + C_W'(1);
        if (cnt == C_W'(R_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, one root bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[R_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sedt_div.sv =====
`default_nettype none
module sedt_div #(
  parameter int N_W = 33,
  parameter int D_W = 11
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic           busy;
  logic [C_W-1:0] cnt;
  logic [D_W-1:0] dvs;
  logic [D_W-1:0] rem;
  logic [D_W:0]   rem_sh;
  logic           fits;

  // restoring step: shift in one dividend bit, subtract if it fits
  assign rem_sh = {rem, quotient[N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + C_W'(1);
        if (cnt == C_W'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? D_W'(rem_sh - {1'b0, dvs}) : rem_sh[D_W-1:0];
      quotient <= {quotient[N_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sedt_engine.sv =====
`default_nettype none
module sedt_engine #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [$clog2(MAX_LEN):0]            n,
  input  wire logic [sedt_pkg::MM_W-1:0]           mm,
  output logic      [$clog2(MAX_LEN)-1:0]          sample_addr,
  input  wire logic [sedt_pkg::SAMPLE_W-1:0]       sample_rdata,
  output logic                                     result_we,
  output logic      [$clog2(MAX_LEN)-1:0]          result_addr,
  output logic      [sedt_pkg::DIST_W-1:0]         result_wdata,
  output logic                                     done
);

  import sedt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  eng_state_t state, state_next;

  logic [AW:0]          n_r;
  logic [AW-1:0]        u;
  logic [AW-1:0]        top;
  logic                 empty;
  logic                 inner;
  logic [AW-1:0]        b;
  logic [AW-1:0]        i;
  logic [SAMPLE_W-1:0]  gu;
  logic [SAMPLE_W-1:0]  gi;
  logic [SQ_W-1:0]      p_bi, p_bu, p_gi, p_gu, p_u, p_i;
  logic                 num_neg;
  logic [SQ_W-1:0]      osq_val;
  logic [SCL_W-1:0]     pos_s, neg_s;

  // segment stack memory: {begin, site}
  logic                 seg_we;
  logic [AW-1:0]        seg_waddr, seg_raddr;
  logic [2*AW-1:0]      seg_wdata, seg_rdata;
  logic [AW-1:0]        seg_rbegin, seg_rsite;

  // outside squared distances, kept between the two passes
  logic                 osq_we;
  logic [AW-1:0]        osq_raddr;
  logic [SQ_W-1:0]      osq_wdata, osq_rdata;

  assign seg_rbegin = seg_rdata[2*AW-1:AW];
  assign seg_rsite  = seg_rdata[AW-1:0];

  sedt_ram #(.WIDTH(2 * AW), .DEPTH(MAX_LEN)) u_seg (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  sedt_ram #(.WIDTH(SQ_W), .DEPTH(MAX_LEN)) u_osq (
    .clk   (clk),
    .we    (osq_we),
    .waddr (u),
    .wdata (osq_wdata),
    .raddr (osq_raddr),
    .rdata (osq_rdata)
  );

  // separator: numerator, denominator and truncating quotient
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic [AW:0]             den;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_q;
  logic signed [W_W-1:0]   q_ext, w, n_lim;
  logic                    w_ok;
  logic [AW:0]             top_inc;

  assign num = $signed(NUM_W'(p_u)) - $signed(NUM_W'(p_i))
             + $signed(NUM_W'(p_gu)) - $signed(NUM_W'(p_gi));
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den     = {u - i, 1'b0};

  sedt_div #(.N_W(NUM_W), .D_W(AW + 1)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ext   = $signed(W_W'(div_q));
  assign w       = num_neg ? (W_W'(1) - q_ext) : (W_W'(1) + q_ext);
  assign n_lim   = $signed(W_W'(n_r)) - W_W'(1);
  assign top_inc = (AW + 1)'(top) + (AW + 1)'(1);
  assign w_ok    = !w[W_W-1] && (w <= n_lim) && (top_inc < (AW + 1)'(MAX_LEN));

  // envelope compare at the top segment's start
  logic [SQ_W:0] f_top, f_new;
  logic          pop_fwd;
  logic [SQ_W:0] sq_sum;
  logic          pop_bwd;

  assign f_top   = (SQ_W + 1)'(p_bi) + (SQ_W + 1)'(p_gi);
  assign f_new   = (SQ_W + 1)'(p_bu) + (SQ_W + 1)'(p_gu);
  assign pop_fwd = f_top > f_new;
  assign sq_sum  = f_top;
  assign pop_bwd = !empty && (u == b);

  // square roots and scaling of both halves
  logic                root_start;
  logic                root_o_done, root_i_done;
  logic [ROOT_W-1:0]   root_o, root_i;
  logic [DIST_W-1:0]   pos_d, neg_d;

  sedt_isqrt #(.RAD_W(RAD_W)) u_sqrt_out (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ({osq_val, FRAC_W'(0)}),
    .done     (root_o_done),
    .root     (root_o)
  );

  sedt_isqrt #(.RAD_W(RAD_W)) u_sqrt_in (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ({sq_sum[SQ_W-1:0], FRAC_W'(0)}),
    .done     (root_i_done),
    .root     (root_i)
  );

  assign pos_d = pos_s[SCL_W-1:FRAC_W];
  assign neg_d = neg_s[SCL_W-1:FRAC_W];

  // squares of signed differences
  logic signed [SQ_W-1:0] d_bi, d_bu, d_ui;
  assign d_bi = $signed(SQ_W'(b)) - $signed(SQ_W'(i));
  assign d_bu = $signed(SQ_W'(b)) - $signed(SQ_W'(u));
  assign d_ui = $signed(SQ_W'(u)) - $signed(SQ_W'(i));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:  if (start) state_next = E_INIT;
      E_INIT:  state_next = (n_r > (AW + 1)'(1)) ? F_RD_U : B_RD;
      F_RD_U:  state_next = F_GU;
      F_GU:    state_next = F_TOP;
      F_TOP:   state_next = empty ? F_NEXT : F_SITE;
      F_SITE:  state_next = F_GI;
      F_GI:    state_next = F_SQ;
      F_SQ:    state_next = F_CMP;
      F_CMP:   state_next = pop_fwd ? F_TOP : F_DIV;
      F_DIV:   if (div_done) state_next = F_NEXT;
      F_NEXT:  state_next = ((AW + 1)'(u) == n_r - (AW + 1)'(1)) ? B_RD : F_RD_U;
      B_RD:    state_next = B_SITE;
      B_SITE:  state_next = B_G;
      B_G:     state_next = B_SQ;
      B_SQ:    state_next = B_SUM;
      B_SUM:   state_next = inner ? B_ROOT : B_NEXT;
      B_ROOT:  if (root_o_done && root_i_done) state_next = B_SCALE;
      B_SCALE: state_next = B_WRITE;
      B_WRITE: state_next = B_NEXT;
      B_NEXT: begin
        if (u == '0) begin
          state_next = inner ? E_IDLE : E_INIT;
        end else begin
          state_next = B_RD;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // memory ports and unit starts
  always_comb begin
    sample_addr  = u;
    seg_we       = 1'b0;
    seg_waddr    = '0;
    seg_wdata    = '0;
    seg_raddr    = top;
    osq_we       = 1'b0;
    osq_raddr    = u;
    osq_wdata    = sq_sum[SQ_W-1:0];
    div_start    = 1'b0;
    root_start   = 1'b0;
    result_we    = 1'b0;
    result_addr  = u;
    result_wdata = pos_d;
    done         = 1'b0;
    unique case (state)
      E_INIT: begin
        seg_we = 1'b1;
      end
      F_TOP: begin
        if (empty) begin
          seg_we    = 1'b1;
          seg_wdata = {AW'(0), u};
        end
      end
      F_SITE:  sample_addr = seg_rsite;
      F_CMP:   div_start = !pop_fwd;
      F_DIV: begin
        if (div_done && w_ok) begin
          seg_we    = 1'b1;
          seg_waddr = top_inc[AW-1:0];
          seg_wdata = {w[AW-1:0], u};
        end
      end
      B_RD:    seg_raddr = empty ? '0 : top;
      B_SITE:  sample_addr = seg_rsite;
      B_SUM: begin
        osq_we     = !inner;
        root_start = inner;
      end
      B_WRITE: begin
        result_we = 1'b1;
        if (neg_d > pos_d) begin
          result_wdata = (neg_d > DIST_MIN) ? DIST_MIN : DIST_W'(-neg_d);
        end else begin
          result_wdata = (pos_d > DIST_MAX) ? DIST_MAX : pos_d;
        end
      end
      B_NEXT:  done = (u == '0) && inner;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      top   <= '0;
      empty <= 1'b0;
      inner <= 1'b0;
      u     <= '0;
      n_r   <= '0;
    end else begin
      state <= state_next;
      case (state)
        E_IDLE: begin
          if (start) begin
            n_r   <= n;
            inner <= 1'b0;
          end
        end
        E_INIT: begin
          top   <= '0;
          empty <= 1'b0;
          u     <= (n_r > (AW + 1)'(1)) ? AW'(1) : '0;
        end
        F_TOP: begin
          if (empty) begin
            top   <= '0;
            empty <= 1'b0;
          end
        end
        F_CMP: begin
          if (pop_fwd) begin
            if (top == '0) begin
              empty <= 1'b1;
            end else begin
              top <= top - AW'(1);
            end
          end
        end
        F_DIV:   if (div_done && w_ok) top <= top_inc[AW-1:0];
        F_NEXT: begin
          if ((AW + 1)'(u) != n_r - (AW + 1)'(1)) begin
            u <= u + AW'(1);
          end
        end
        B_SUM: begin
          if (pop_bwd) begin
            if (top == '0) begin
              empty <= 1'b1;
            end else begin
              top <= top - AW'(1);
            end
          end
        end
        B_NEXT: begin
          if (u == '0) begin
            inner <= 1'b1;
          end else begin
            u <= u - AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_GU:    gu <= gval(sample_rdata, inner);
      F_SITE, B_SITE: begin
        b <= seg_rbegin;
        i <= seg_rsite;
      end
      F_GI:    gi <= gval(sample_rdata, inner);
      F_SQ: begin
        p_bi <= SQ_W'(d_bi * d_bi);
        p_bu <= SQ_W'(d_bu * d_bu);
        p_gi <= SQ_W'(gi) * SQ_W'(gi);
        p_gu <= SQ_W'(gu) * SQ_W'(gu);
        p_u  <= SQ_W'(u) * SQ_W'(u);
        p_i  <= SQ_W'(i) * SQ_W'(i);
      end
      F_CMP:   num_neg <= num[NUM_W-1];
      B_G: begin
        gi      <= gval(sample_rdata, inner);
        osq_val <= osq_rdata;
      end
      B_SQ: begin
        p_bi <= SQ_W'(d_ui * d_ui);
        p_gi <= SQ_W'(gi) * SQ_W'(gi);
      end
      B_SCALE: begin
        pos_s <= SCL_W'(root_o) * SCL_W'(mm);
        neg_s <= SCL_W'(root_i) * SCL_W'(mm);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/signed_edt_row_pass_top.sv =====
`default_nettype none
// channel   signals                          word
// -------   ------------------------------   -------------------------------
// req       req_valid / req_ready / req      func, sample, row_end
// rsp       rsp_valid / rsp_ready / rsp      position, distance, final_res
// cfg       cfg_we / cfg_wdata               mm_per_pixel (Q8.16)
//
// Load words can be accepted back to back. A fetch word is accepted, fetch_pend
// is set while the results memory is read, then the result is loaded into the
// output register; req_ready is low while fetch_pend is set, so a fetch waits for
// the previous result, and a stalled result holds req_ready low.
// The last sample of a row starts the two envelope passes; each forward scan
// runs the divider once per separator and loops back per popped segment, and
// the inside backward scan runs both 24-step square roots side by side.
// req_ready stays low until both passes are done.
// Reset (synchronous) empties the row; memories are not cleared.
module signed_edt_row_pass_top #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_ready,
  input  wire sedt_pkg::req_t            req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_ready,
  output sedt_pkg::rsp_t                 rsp,
  input  wire logic                      cfg_we,
  input  wire logic [sedt_pkg::MM_W-1:0] cfg_wdata
);

  import sedt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);

  phase_t             phase, phase_next;
  logic [MM_W-1:0]    mm;
  logic [AW:0]        load_count;
  logic [AW:0]        read_index;
  logic               fetch_pend;

  logic               acc;
  logic               load_acc;
  logic               fetch_acc;
  logic [AW:0]        load_base;
  logic [AW:0]        load_next;
  logic               load_fits;
  logic               last_read;

  logic [AW-1:0]      sample_raddr;
  logic [SAMPLE_W-1:0] sample_rdata;
  logic               result_we;
  logic [AW-1:0]      result_waddr;
  logic [DIST_W-1:0]  result_wdata;
  logic [DIST_W-1:0]  result_rdata;
  logic               eng_done;
  logic               eng_start;

  assign acc       = req_valid && req_ready;
  assign load_acc  = acc && (req.func == FUNC_LOAD);
  assign fetch_acc = acc && (req.func == FUNC_FETCH) && (phase == PH_READ);
  assign load_base = (phase == PH_READ) ? '0 : load_count;
  assign load_fits = load_base < (AW + 1)'(MAX_LEN);
  assign load_next = load_fits ? load_base + (AW + 1)'(1) : load_base;
  assign last_read = (read_index + (AW + 1)'(1)) >= load_count;
  assign eng_start = load_acc && req.row_end;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LOAD: if (eng_start) phase_next = PH_CALC;
      PH_CALC: if (eng_done) phase_next = PH_READ;
      PH_READ: begin
        if (load_acc) begin
          phase_next = req.row_end ? PH_CALC : PH_LOAD;
        end else if (fetch_acc && last_read) begin
          phase_next = PH_LOAD;
        end
      end
      default: phase_next = PH_LOAD;
    endcase
  end

  // accept a word only when idle and the output register frees up
  always_comb begin
    unique case (phase)
      PH_CALC: req_ready = 1'b0;
      default: req_ready = !fetch_pend && (!rsp_valid || rsp_ready);
    endcase
  end

  // counters, scale register and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LOAD;
      mm         <= MM_RESET;
      load_count <= '0;
      read_index <= '0;
      fetch_pend <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      fetch_pend <= fetch_acc;
      if (cfg_we) begin
        mm <= cfg_wdata;
      end
      if (load_acc) begin
        load_count <= load_next;
        read_index <= '0;
      end else if (fetch_acc) begin
        if (last_read) begin
          load_count <= '0;
          read_index <= '0;
        end else begin
          read_index <= read_index + (AW + 1)'(1);
        end
      end
      if (fetch_pend) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // output word: position and last flag at accept, distance from the memory
  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      rsp.position  <= POS_W'(read_index);
      rsp.final_res <= (read_index + (AW + 1)'(1)) == load_count;
    end
    if (fetch_pend) begin
      rsp.distance <= result_rdata;
    end
  end

  sedt_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_samples (
    .clk   (clk),
    .we    (load_acc && load_fits),
    .waddr (load_base[AW-1:0]),
    .wdata (req.sample),
    .raddr (sample_raddr),
    .rdata (sample_rdata)
  );

  sedt_ram #(.WIDTH(DIST_W), .DEPTH(MAX_LEN)) u_results (
    .clk   (clk),
    .we    (result_we),
    .waddr (result_waddr),
    .wdata (result_wdata),
    .raddr (read_index[AW-1:0]),
    .rdata (result_rdata)
  );

  sedt_engine #(.MAX_LEN(MAX_LEN)) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (eng_start),
    .n            (load_next),
    .mm           (mm),
    .sample_addr  (sample_raddr),
    .sample_rdata (sample_rdata),
    .result_we    (result_we),
    .result_addr  (result_waddr),
    .result_wdata (result_wdata),
    .done         (eng_done)
  );

endmodule
`default_nettype wire

// ===== rtl/sedt_checker.sv =====
`default_nettype none
module sedt_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire sedt_pkg::req_t            req,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire sedt_pkg::rsp_t            rsp
);

  import sedt_pkg::*;

  // hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // drop ready while a row is computed
  a_busy_after_row_end: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.func == FUNC_LOAD) && req.row_end |=> !req_ready)
    else $error("ready high right after row end");

  // a load word never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.func == FUNC_LOAD) |=> !$rose(rsp_valid))
    else $error("result after load word");

  // no new word while a result is still pending in the output register
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("word accepted with a stalled result");

endmodule

bind signed_edt_row_pass_top sedt_checker u_checker (.*);
`default_nettype wire
